// ----- hw/rtl/rdt_pkg.sv -----
// Shared constants, codes and types for the rotation direction tracker.
`timescale 1ns / 1ps

package rdt_pkg;

  // Field and state widths
  localparam int ANGLE_W  = 17;
  localparam int DELTA_W  = 12;
  localparam int RATE_W   = 9;
  localparam int PERIOD_W = 8;
  localparam int QUAD_W   = 3;
  localparam int CFG_IDX_W = 1;

  // Fixed point scale of the angle, fractional bits per degree
  localparam int ANGLE_FRAC_BITS = 7;

  // Q1.8 weight of one
  localparam logic [RATE_W-1:0] RATE_ONE = RATE_W'(256);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SMOOTHING_RATE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_UPDATE_PERIOD  = 1'b1;

  // Register reset values
  localparam logic [RATE_W-1:0]   RATE_RESET   = RATE_W'(128);
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(15);

  // Quadrant codes
  localparam logic [QUAD_W-1:0] QUAD_ORIGIN = 3'd0;
  localparam logic [QUAD_W-1:0] QUAD_ONE    = 3'd1;
  localparam logic [QUAD_W-1:0] QUAD_TWO    = 3'd2;
  localparam logic [QUAD_W-1:0] QUAD_THREE  = 3'd3;
  localparam logic [QUAD_W-1:0] QUAD_FOUR   = 3'd4;

  // Spin direction codes
  typedef enum logic [1:0] {
    SPIN_NONE = 2'd0,
    SPIN_CW   = 2'd1,
    SPIN_CCW  = 2'd2
  } spin_t;

  // Status handed from the tracker to the result register
  typedef struct packed {
    spin_t spin;
    logic  updated;
  } track_status_t;

endpackage

// ----- hw/rtl/rotation_direction_tracker_core.sv -----
// Top level of the rotation direction tracker: ports, registers and result stage.
`timescale 1ns / 1ps

// The tracker takes one target angle per cycle and returns one result per
// angle: its quadrant, the spin direction after this item and a flag for items
// that re-evaluated the direction. A transaction is held in an input register,
// processed against the tracker state and placed in a result register, so a
// result passes the input register and then the result register, and the
// sustained rate of one item per cycle holds while out_ready is high.
// A result that waits on out_ready holds back processing of the next angle, and
// once the input register is full as well the input stalls. Write the
// smoothing rate and update period only while no transaction is in flight.
module rotation_direction_tracker_core
  import rdt_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [ANGLE_W-1:0] target_angle,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [QUAD_W-1:0]         quadrant,
  output logic [1:0]                spin_direction,
  output logic                      direction_updated,
  input  logic                      cfg_write,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [RATE_W-1:0]         cfg_data
);

  logic [RATE_W-1:0]         smoothing_rate;
  logic [PERIOD_W-1:0]       update_period;
  logic                      in_full;
  logic signed [ANGLE_W-1:0] in_angle;
  logic                      fire;
  logic [QUAD_W-1:0]         quadrant_next;
  track_status_t             status;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      smoothing_rate <= RATE_RESET;
      update_period  <= PERIOD_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_SMOOTHING_RATE: smoothing_rate <= cfg_data;
        CFG_UPDATE_PERIOD:  update_period  <= cfg_data[PERIOD_W-1:0];
        default: ;
      endcase
    end
  end

  // Process the held transaction when the result stage can take it
  assign fire     = in_full && (!out_valid || out_ready);
  assign in_ready = !in_full || fire;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ready) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_angle <= target_angle;
    end
  end

  rdt_classify u_classify (
    .angle    (in_angle),
    .quadrant (quadrant_next)
  );

  rdt_tracker u_tracker (
    .clk            (clk),
    .rst            (rst),
    .step           (fire),
    .angle          (in_angle),
    .smoothing_rate (smoothing_rate),
    .update_period  (update_period),
    .status         (status)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      quadrant          <= quadrant_next;
      spin_direction    <= status.spin;
      direction_updated <= status.updated;
    end
  end

endmodule

// ----- hw/rtl/rdt_classify.sv -----
// Quadrant classification of one target angle.
`timescale 1ns / 1ps

module rdt_classify
  import rdt_pkg::*;
(
  input  logic signed [ANGLE_W-1:0] angle,
  output logic [QUAD_W-1:0]         quadrant
);

  // Compare at a width that holds 360 degrees at the largest scale
  localparam int CMP_W = 21;
  localparam logic signed [CMP_W-1:0] DEG_90  = CMP_W'(90  << ANGLE_FRAC_BITS);
  localparam logic signed [CMP_W-1:0] DEG_180 = CMP_W'(180 << ANGLE_FRAC_BITS);
  localparam logic signed [CMP_W-1:0] DEG_270 = CMP_W'(270 << ANGLE_FRAC_BITS);
  localparam logic signed [CMP_W-1:0] DEG_360 = CMP_W'(360 << ANGLE_FRAC_BITS);

  logic signed [CMP_W-1:0] a_ext;

  assign a_ext = CMP_W'(angle);

  // Pick the quadrant by range, origin outside 0..360
  always_comb begin
    priority if (a_ext < 0)        quadrant = QUAD_ORIGIN;
    else if (a_ext < DEG_90)       quadrant = QUAD_TWO;
    else if (a_ext < DEG_180)      quadrant = QUAD_ONE;
    else if (a_ext < DEG_270)      quadrant = QUAD_FOUR;
    else if (a_ext <= DEG_360)     quadrant = QUAD_THREE;
    else                           quadrant = QUAD_ORIGIN;
  end

endmodule

// ----- hw/rtl/rdt_tracker.sv -----
// Frame counter, smoothed angle delta and held spin direction.
`timescale 1ns / 1ps

module rdt_tracker
  import rdt_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      step,
  input  logic signed [ANGLE_W-1:0] angle,
  input  logic [RATE_W-1:0]         smoothing_rate,
  input  logic [PERIOD_W-1:0]       update_period,
  output track_status_t             status
);

  localparam int DIFF_W = ANGLE_W + 1;
  localparam int ERR_W  = DELTA_W + 2;
  localparam int PROD_W = ERR_W + RATE_W + 1;
  localparam int STEP_W = PROD_W - 8;
  localparam int SUM_W  = STEP_W + 1;
  localparam logic signed [DIFF_W-1:0] DIFF_LIMIT = DIFF_W'(10 << ANGLE_FRAC_BITS);
  localparam logic signed [ERR_W-1:0]  SPIN_LIMIT = ERR_W'(2 << ANGLE_FRAC_BITS);
  localparam logic signed [SUM_W-1:0]  DELTA_MAX  = SUM_W'((1 << (DELTA_W - 1)) - 1);
  localparam logic signed [SUM_W-1:0]  DELTA_MIN  = -SUM_W'(1 << (DELTA_W - 1));

  logic [PERIOD_W-1:0]       frame_count;
  logic signed [ANGLE_W-1:0] last_angle;
  logic signed [DELTA_W-1:0] smoothed_delta;
  spin_t                     held_direction;

  logic [PERIOD_W:0]         count;
  logic                      evaluate;
  logic signed [DIFF_W-1:0]  diff;
  logic                      in_window;
  logic [RATE_W-1:0]         rate;
  logic signed [ERR_W-1:0]   err;
  logic signed [PROD_W-1:0]  prod;
  logic signed [STEP_W-1:0]  delta_step;
  logic signed [SUM_W-1:0]   sum;
  logic signed [DELTA_W-1:0] smoothed_delta_next;
  logic signed [ERR_W-1:0]   delta_ext;
  spin_t                     held_direction_next;

  // Count items and decide whether this one re-evaluates
  assign count    = {1'b0, frame_count} + 1'b1;
  assign evaluate = count >= {1'b0, update_period};

  // Angle change since the last evaluated sample and the averaging window
  assign diff      = DIFF_W'(angle) - DIFF_W'(last_angle);
  assign in_window = (diff != '0) && (diff < DIFF_LIMIT) && (diff > -DIFF_LIMIT);

  // Saturate the weight at one
  assign rate = (smoothing_rate > RATE_ONE) ? RATE_ONE : smoothing_rate;

  // Exponential average step, floor of the Q1.8 product
  assign err        = ERR_W'(diff) - ERR_W'(smoothed_delta);
  assign prod       = $signed({1'b0, rate}) * err;
  assign delta_step = prod[PROD_W-1:8];
  assign sum        = SUM_W'(smoothed_delta) + SUM_W'(delta_step);

  // Clamp to the average's range, keep it outside the window
  always_comb begin
    priority if (!in_window)    smoothed_delta_next = smoothed_delta;
    else if (sum > DELTA_MAX)   smoothed_delta_next = DELTA_MAX[DELTA_W-1:0];
    else if (sum < DELTA_MIN)   smoothed_delta_next = DELTA_MIN[DELTA_W-1:0];
    else                        smoothed_delta_next = sum[DELTA_W-1:0];
  end

  // Direction from the updated average
  assign delta_ext = ERR_W'(smoothed_delta_next);
  always_comb begin
    priority if (delta_ext > SPIN_LIMIT)   held_direction_next = SPIN_CW;
    else if (delta_ext < -SPIN_LIMIT)      held_direction_next = SPIN_CCW;
    else                                   held_direction_next = SPIN_NONE;
  end

  // Advance the state on each processed transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_count    <= '0;
      last_angle     <= '0;
      smoothed_delta <= '0;
      held_direction <= SPIN_NONE;
    end else if (step) begin
      if (evaluate) begin
        frame_count    <= '0;
        last_angle     <= angle;
        smoothed_delta <= smoothed_delta_next;
        held_direction <= held_direction_next;
      end else begin
        frame_count <= count[PERIOD_W-1:0];
      end
    end
  end

  assign status.spin    = evaluate ? held_direction_next : held_direction;
  assign status.updated = evaluate;

endmodule
